// File: hdl/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg
// shared types, constants and arithmetic helpers of the skinning engine
// ----------------------------------------------------------------------------
package lbs_pkg;

    localparam int MAT_ELEMS = 12;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef enum logic {
        KIND_PALETTE = 1'b0,
        KIND_INFLUENCE = 1'b1
    } kind_t;

    // saturate a 34-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        hi = 34'sh0_7FFF_FFFF;
        lo = -34'sh0_8000_0000;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // saturate a 50-bit signed row sum to 32 bits
    function automatic logic signed [31:0] sat50(input logic signed [49:0] v);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = 50'sh0_7FFF_FFFF;
        lo = -50'sh0_8000_0000;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// File: hdl/lbs_ram.sv
// ----------------------------------------------------------------------------
// lbs_ram
// generic simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module lbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hdl/lbs_mac.sv
// ----------------------------------------------------------------------------
// lbs_mac
// one palette element times one vector component, floored to q32.16
// ----------------------------------------------------------------------------
module lbs_mac (
    input  logic               aclk,
    input  logic signed [31:0] m_elem,
    input  logic signed [31:0] v_comp,
    output logic signed [47:0] prod_q16_reg
);
    logic signed [63:0] prod;

    assign prod = m_elem * v_comp;

    always_ff @(posedge aclk) begin
        prod_q16_reg <= prod[63:16];
    end
endmodule

// File: hdl/linear_blend_skinning.sv
// ----------------------------------------------------------------------------
// linear_blend_skinning
// vertex skinning engine with a joint matrix palette in a ram
// ----------------------------------------------------------------------------
// channel  | ports                         | accepted when
// input    | s_valid s_ready s_<field>     | s_valid && s_ready
// result   | m_valid m_ready m_out_<field> | m_valid && m_ready
//
// palette writes complete on acceptance; an influence passes the accepting
// cycle, twelve palette reads through the single ram port, one element per
// cycle, plus a drain of the product pipe, then a weighting step for each
// component; position and normal each have a multiplier
// reset clears accumulators, skip flag and handshake state; no palette clear
// a held result blocks only the final influence of the next vertex
// ----------------------------------------------------------------------------
module linear_blend_skinning #(
    parameter int MAX_JOINTS = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [7:0]         s_joint_index,
    input  logic [3:0]         s_element_index,
    input  logic signed [31:0] s_element_value,
    input  logic [16:0]        s_blend_weight,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [31:0] s_nrm_x,
    input  logic signed [31:0] s_nrm_y,
    input  logic signed [31:0] s_nrm_z,
    input  logic               s_last_influence,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_pos_x,
    output logic signed [31:0] m_out_pos_y,
    output logic signed [31:0] m_out_pos_z,
    output logic signed [31:0] m_out_nrm_x,
    output logic signed [31:0] m_out_nrm_y,
    output logic signed [31:0] m_out_nrm_z
);
    localparam int DEPTH = MAX_JOINTS * lbs_pkg::MAT_ELEMS;
    localparam int AW = $clog2(DEPTH);

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_WEIGHT} state_t;

    state_t state_reg;
    logic [3:0] cnt_reg;          // element / component counter
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] nrm_reg [3];
    logic [16:0] w_reg;
    logic last_reg;
    logic use_reg;                // influence adds into the accumulators
    logic [AW-1:0] base_reg;
    logic signed [49:0] sp_reg [3]; // transformed position row sums
    logic signed [49:0] sn_reg [3]; // transformed normal row sums
    logic signed [31:0] acc_pos_reg [3];
    logic signed [31:0] acc_nrm_reg [3];
    logic skip_reg;
    logic valid_reg;
    logic signed [31:0] out_reg [6];
    logic [3:0] el_d_reg;         // element whose ram data is now out
    logic rd_d_reg;

    // ram port: write in idle, read during the read phase
    logic we;
    logic [AW-1:0] waddr, raddr;
    logic signed [31:0] rdata;
    logic [1:0] col_d;
    logic signed [31:0] vcomp;
    logic signed [47:0] prod;
    logic [3:0] el_p_reg;
    logic pr_p_reg;
    logic [1:0] row_p, col_p;
    logic signed [31:0] tp, tn;
    logic [1:0] wi;
    logic signed [48:0] cp, cn;
    logic signed [31:0] ap, an;
    logic joint_ok;
    logic [16:0] w_clip;

    assign joint_ok = 32'(s_joint_index) < 32'(MAX_JOINTS);
    assign we = (state_reg == ST_IDLE) && s_valid && s_ready
             && (s_kind == lbs_pkg::KIND_PALETTE) && joint_ok
             && (s_element_index < 4'(lbs_pkg::MAT_ELEMS));
    assign waddr = AW'(32'(s_joint_index) * lbs_pkg::MAT_ELEMS + 32'(s_element_index));
    assign raddr = base_reg + AW'(cnt_reg);

    lbs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .aclk(aclk), .we(we), .waddr(we ? waddr : raddr), .wdata(s_element_value),
        .raddr(raddr), .rdata(rdata)
    );

    assign col_d = el_d_reg[1:0];
    assign vcomp = (col_d == 2'd3) ? 32'sd0 : pos_reg[col_d];

    // position product through the mac instance; normal uses its own multiplier, same cycle
    lbs_mac u_mac (.aclk(aclk), .m_elem(rdata), .v_comp(vcomp), .prod_q16_reg(prod));

    logic signed [47:0] nprod_reg;
    logic signed [31:0] tr_reg;
    logic signed [31:0] ncomp;
    logic signed [63:0] nprod_full;

    assign ncomp = (col_d == 2'd3) ? 32'sd0 : nrm_reg[col_d];
    assign nprod_full = rdata * ncomp;

    always_ff @(posedge aclk) begin
        nprod_reg <= nprod_full[63:16];
        tr_reg <= rdata;
    end

    assign row_p = 2'(el_p_reg >> 2);
    assign col_p = el_p_reg[1:0];
    assign wi = cnt_reg[1:0];
    assign tp = lbs_pkg::sat50(sp_reg[wi]);
    assign tn = lbs_pkg::sat50(sn_reg[wi]);
    assign cp = 49'((tp * $signed({1'b0, w_reg})) >>> 16);
    assign cn = 49'((tn * $signed({1'b0, w_reg})) >>> 16);
    assign ap = lbs_pkg::sat34(34'(acc_pos_reg[wi]) + 34'(cp));
    assign an = lbs_pkg::sat34(34'(acc_nrm_reg[wi]) + 34'(cn));
    assign w_clip = (s_blend_weight > lbs_pkg::ONE_Q16) ? lbs_pkg::ONE_Q16 : s_blend_weight;

    assign s_ready = (state_reg == ST_IDLE)
                  && !(s_kind == lbs_pkg::KIND_INFLUENCE && s_last_influence && valid_reg);
    assign m_valid = valid_reg;
    assign m_out_pos_x = out_reg[0];
    assign m_out_pos_y = out_reg[1];
    assign m_out_pos_z = out_reg[2];
    assign m_out_nrm_x = out_reg[3];
    assign m_out_nrm_y = out_reg[4];
    assign m_out_nrm_z = out_reg[5];

    always_ff @(posedge aclk) begin
        rd_d_reg <= (state_reg == ST_READ) && (cnt_reg < 4'(lbs_pkg::MAT_ELEMS));
        el_d_reg <= cnt_reg;
        pr_p_reg <= rd_d_reg;
        el_p_reg <= el_d_reg;
        if (pr_p_reg) begin
            // partial products arrive one element per cycle
            if (col_p == 2'd3) begin
                sp_reg[row_p] <= sp_reg[row_p] + 50'(tr_reg);
            end else begin
                sp_reg[row_p] <= sp_reg[row_p] + 50'(prod);
                sn_reg[row_p] <= sn_reg[row_p] + 50'(nprod_reg);
            end
        end
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            valid_reg <= 1'b0;
            skip_reg <= 1'b0;
            rd_d_reg <= 1'b0;
            pr_p_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                acc_pos_reg[i] <= '0;
                acc_nrm_reg[i] <= '0;
            end
        end else begin
            if (valid_reg && m_ready) begin
                valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready && s_kind == lbs_pkg::KIND_INFLUENCE) begin
                        pos_reg[0] <= s_pos_x; pos_reg[1] <= s_pos_y; pos_reg[2] <= s_pos_z;
                        nrm_reg[0] <= s_nrm_x; nrm_reg[1] <= s_nrm_y; nrm_reg[2] <= s_nrm_z;
                        w_reg <= w_clip;
                        last_reg <= s_last_influence;
                        use_reg <= !skip_reg && (w_clip != '0) && joint_ok;
                        if (w_clip == '0) begin
                            skip_reg <= 1'b1;
                        end
                        base_reg <= AW'(32'(s_joint_index) * lbs_pkg::MAT_ELEMS);
                        for (int i = 0; i < 3; i++) begin
                            sp_reg[i] <= '0;
                            sn_reg[i] <= '0;
                        end
                        cnt_reg <= '0;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    // 12 reads, then drain the product pipe
                    if (cnt_reg == 4'(lbs_pkg::MAT_ELEMS + 1)) begin
                        cnt_reg <= '0;
                        state_reg <= ST_WEIGHT;
                    end else begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                ST_WEIGHT: begin
                    if (use_reg) begin
                        acc_pos_reg[wi] <= ap;
                        acc_nrm_reg[wi] <= an;
                    end
                    if (wi == 2'd2) begin
                        state_reg <= ST_IDLE;
                        if (last_reg) begin
                            for (int i = 0; i < 3; i++) begin
                                out_reg[i] <= (use_reg && i == 2) ? ap : acc_pos_reg[i];
                                out_reg[3 + i] <= (use_reg && i == 2) ? an : acc_nrm_reg[i];
                                acc_pos_reg[i] <= '0;
                                acc_nrm_reg[i] <= '0;
                            end
                            skip_reg <= 1'b0;
                            valid_reg <= 1'b1;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !m_ready) |=> valid_reg) else $error("result dropped");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WEIGHT |-> cnt_reg < 4'd3) else $error("weight counter");
`endif
endmodule
